// ----- rtl/lsbd_pkg.sv -----
// Package for the lidar scan boundary detector.
// Holds the payload structs, configuration codes and fixed constants.
// No dependencies.
package lsbd_pkg;

    localparam int unsigned FULL_TURN      = 36000;
    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned AZ_OFFSET_W    = 11;
    localparam int unsigned ANGLE_W        = 16;
    localparam int unsigned LEN_W          = 12;
    localparam int unsigned OUT_COUNT_W    = 12;

    localparam logic [AZ_OFFSET_W-1:0] AZ_OFFSET_RST   = 11'd2;
    localparam logic [ANGLE_W-1:0]     START_ANGLE_RST = 16'd0;
    localparam logic [LEN_W-1:0]       LEN_A_RST       = 12'd1262;
    localparam logic [LEN_W-1:0]       LEN_B_RST       = 12'd1266;

    typedef enum logic [1:0] {
        CFG_AZ_OFFSET   = 2'd0,
        CFG_START_ANGLE = 2'd1,
        CFG_LEN_A       = 2'd2,
        CFG_LEN_B       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [AZ_OFFSET_W-1:0] azimuth_offset;
        logic [ANGLE_W-1:0]     start_angle;     // already reduced mod FULL_TURN
        logic [LEN_W-1:0]       valid_length_a;
        logic [LEN_W-1:0]       valid_length_b;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_lidar;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                   packet_accepted;
        logic [ANGLE_W-1:0]     phase;
        logic                   scan_end;
        logic [OUT_COUNT_W-1:0] packets_in_scan;
        logic [LEN_W-1:0]       packet_length;
    } t_out_item;

    // Packet record handed from front to back.
    typedef struct packed {
        logic               accepted;
        logic [ANGLE_W-1:0] azimuth;
        logic [LEN_W-1:0]   length;
    } t_pkt_rec;

endpackage

// ----- rtl/lsbd_fifo.sv -----
// Small register FIFO, combinational read of the head entry.
// Standalone; no package dependency.
module lsbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/lsbd_front.sv -----
// Front end: counts packet bytes, captures azimuth, qualifies the packet.
// Uses lsbd_pkg; emits one t_pkt_rec per final byte.
module lsbd_front #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsbd_pkg::t_cfg    i_cfg,
    input  logic              i_push,
    input  lsbd_pkg::t_in_item i_in,
    input  logic              i_stall,
    output logic              o_rec_push,
    output lsbd_pkg::t_pkt_rec o_rec
);
    import lsbd_pkg::*;

    localparam int BCW  = $clog2(MAX_PACKET_BYTES + 2);
    localparam int CMPW = (BCW > LEN_W) ? BCW : LEN_W;
    localparam logic [CMPW-1:0] MAX_B = CMPW'(MAX_PACKET_BYTES);

    logic [BCW-1:0]  r_byte_cnt, n_byte_cnt;
    logic [7:0]      r_az_lo, n_az_lo;
    logic [7:0]      r_az_hi, n_az_hi;
    logic            take;
    logic [CMPW-1:0] idx, len, off_lo, off_hi;
    logic            len_ok;

    assign take   = i_push && !i_stall;
    assign idx    = CMPW'(r_byte_cnt);
    assign off_lo = CMPW'(i_cfg.azimuth_offset);
    assign off_hi = CMPW'(i_cfg.azimuth_offset) + 1'b1;

    always_comb begin
        n_az_lo = r_az_lo;
        n_az_hi = r_az_hi;
        if (idx < MAX_B) begin
            if (idx == off_lo) n_az_lo = i_in.data_byte;
            if (idx == off_hi) n_az_hi = i_in.data_byte;
        end
        // counter parks at MAX+1 for oversized packets
        len    = (idx <= MAX_B) ? idx + 1'b1 : idx;
        len_ok = (len <= MAX_B) &&
                 ((len == CMPW'(i_cfg.valid_length_a)) ||
                  (len == CMPW'(i_cfg.valid_length_b)));
        n_byte_cnt = BCW'(len);

        o_rec_push     = take && i_in.last_byte;
        o_rec.accepted = i_in.is_lidar && len_ok;
        o_rec.azimuth  = {n_az_hi, n_az_lo};
        o_rec.length   = LEN_W'((len > MAX_B) ? MAX_B : len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_az_lo    <= '0;
            r_az_hi    <= '0;
        end else if (take) begin
            if (i_in.last_byte) begin
                r_byte_cnt <= '0;
                r_az_lo    <= '0;
                r_az_hi    <= '0;
            end else begin
                r_byte_cnt <= n_byte_cnt;
                r_az_lo    <= n_az_lo;
                r_az_hi    <= n_az_hi;
            end
        end
    end

endmodule

// ----- rtl/lsbd_back.sv -----
// Back end: phase computation and scan tracking per packet record.
// Uses lsbd_pkg; consumes t_pkt_rec, produces t_out_item.
module lsbd_back #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [lsbd_pkg::ANGLE_W-1:0] i_start_angle,
    input  logic               i_rec_valid,
    input  lsbd_pkg::t_pkt_rec i_rec,
    output logic               o_rec_pop,
    input  logic               i_out_full,
    output logic               o_out_push,
    output lsbd_pkg::t_out_item o_out
);
    import lsbd_pkg::*;

    localparam logic [ANGLE_W:0] TURN = (ANGLE_W + 1)'(FULL_TURN);

    logic [ANGLE_W-1:0]     r_prev_phase;
    logic [COUNT_WIDTH-1:0] r_scan_cnt;
    logic [ANGLE_W:0]       az_red, diff;
    logic [ANGLE_W-1:0]     phase;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   closes, fire;

    assign fire       = i_rec_valid && !i_out_full;
    assign o_rec_pop  = fire;
    assign o_out_push = fire;

    always_comb begin
        az_red  = ({1'b0, i_rec.azimuth} >= TURN) ? {1'b0, i_rec.azimuth} - TURN
                                                  : {1'b0, i_rec.azimuth};
        diff    = az_red - {1'b0, i_start_angle};
        phase   = diff[ANGLE_W] ? ANGLE_W'(diff + TURN) : diff[ANGLE_W-1:0];
        cnt_inc = (r_scan_cnt != '1) ? r_scan_cnt + 1'b1 : r_scan_cnt;
        closes  = phase < r_prev_phase;

        o_out.packet_accepted = i_rec.accepted;
        o_out.packet_length   = i_rec.length;
        if (i_rec.accepted) begin
            o_out.phase           = phase;
            o_out.scan_end        = closes;
            o_out.packets_in_scan = OUT_COUNT_W'(cnt_inc);
        end else begin
            o_out.phase           = '0;
            o_out.scan_end        = 1'b0;
            o_out.packets_in_scan = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase <= '0;
            r_scan_cnt   <= '0;
        end else if (fire && i_rec.accepted) begin
            if (closes) begin
                r_prev_phase <= '0;
                r_scan_cnt   <= '0;
            end else begin
                r_prev_phase <= phase;
                r_scan_cnt   <= cnt_inc;
            end
        end
    end

endmodule

// ----- rtl/lidar_scan_boundary_detector.sv -----
// Lidar scan boundary detector, top level. Uses lsbd_pkg, lsbd_front, lsbd_back, lsbd_fifo.
// Throughput: one byte per cycle sustained; full rises only when both queues back up.
// A packet's record is registered in the packet queue, its result word in the result queue.
// Reset (sync, active low): registers to defaults, byte count, azimuth, scan state cleared,
// both queues empty.
module lidar_scan_boundary_detector #(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int COUNT_WIDTH      = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte stream in
    input  logic                i_push,
    input  lsbd_pkg::t_in_item  i_in,
    output logic                o_full,
    // per-packet result words out
    input  logic                i_pop,
    output lsbd_pkg::t_out_item o_out,
    output logic                o_empty,
    // config writes
    input  logic                i_cfg_we,
    input  lsbd_pkg::t_cfg_idx  i_cfg_index,
    input  logic [lsbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lsbd_pkg::*;

    localparam int REC_W = $bits(t_pkt_rec);
    localparam int OUT_W = $bits(t_out_item);

    t_cfg      r_cfg;
    logic      rec_push, rec_full, rec_pop, rec_empty;
    t_pkt_rec  rec_in, rec_out;
    logic      out_push, out_full;
    t_out_item out_word;
    logic [REC_W-1:0] rec_raw;
    logic [OUT_W-1:0] out_raw;

    // Config registers. Scan start angle is reduced mod a full turn on the write,
    // so the back end only ever subtracts an in-range angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.azimuth_offset <= AZ_OFFSET_RST;
            r_cfg.start_angle    <= START_ANGLE_RST;
            r_cfg.valid_length_a <= LEN_A_RST;
            r_cfg.valid_length_b <= LEN_B_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AZ_OFFSET:   r_cfg.azimuth_offset <= i_cfg_data[AZ_OFFSET_W-1:0];
                CFG_START_ANGLE: r_cfg.start_angle <=
                    (i_cfg_data >= ANGLE_W'(FULL_TURN)) ? i_cfg_data - ANGLE_W'(FULL_TURN)
                                                        : i_cfg_data;
                CFG_LEN_A:       r_cfg.valid_length_a <= i_cfg_data[LEN_W-1:0];
                CFG_LEN_B:       r_cfg.valid_length_b <= i_cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // Input stalls whenever the packet queue is full (conservative: also on
    // non-final bytes), keeping the front free of a second hold path.
    assign o_full = rec_full;

    lsbd_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (i_push),
        .i_in       (i_in),
        .i_stall    (rec_full),
        .o_rec_push (rec_push),
        .o_rec      (rec_in)
    );

    // Front-to-back packet queue.
    lsbd_fifo #(
        .WIDTH(REC_W),
        .DEPTH(2)
    ) u_rec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (rec_full),
        .i_pop   (rec_pop),
        .o_data  (rec_raw),
        .o_empty (rec_empty)
    );
    assign rec_out = t_pkt_rec'(rec_raw);

    lsbd_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_angle (r_cfg.start_angle),
        .i_rec_valid   (!rec_empty),
        .i_rec         (rec_out),
        .o_rec_pop     (rec_pop),
        .i_out_full    (out_full),
        .o_out_push    (out_push),
        .o_out         (out_word)
    );

    // Result queue: decouples the back end from the consumer.
    lsbd_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_word),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_raw),
        .o_empty (o_empty)
    );
    assign o_out = t_out_item'(out_raw);

endmodule

// ----- rtl/lsbd_checker.sv -----
// Port-level checker for lidar_scan_boundary_detector, plus its bind.
// Uses lsbd_pkg; sees top-level ports only.
module lsbd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_full,
    input logic                i_pop,
    input lsbd_pkg::t_out_item o_out,
    input logic                o_empty
);
    import lsbd_pkg::*;

    // queues come up empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty && !o_full)
        else $error("queues not empty after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out))
        else $error("result word changed while stalled");

    // rejected packets carry no scan info
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_out.packet_accepted |->
            o_out.phase == '0 && !o_out.scan_end && o_out.packets_in_scan == '0)
        else $error("rejected packet with scan fields set");

    // phase always in range
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_out.phase < ANGLE_W'(FULL_TURN))
        else $error("phase out of range");

    // every packet has at least its final byte
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_out.packet_length != '0)
        else $error("zero packet length");

endmodule

bind lidar_scan_boundary_detector lsbd_checker u_lsbd_checker (.*);

// ----- dv/tb_lidar_scan_boundary_detector.sv -----
// Self-checking testbench for lidar_scan_boundary_detector: byte stream in, packet results out.
// Drives the byte queue and config port, predicts each packet's result word and checks it.
// Depends on rtl/lsbd_pkg.sv and the detector RTL.
module tb_lidar_scan_boundary_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbd_pkg::*;

    localparam int unsigned MAX_BYTES   = 2048;
    localparam int unsigned CNT_W       = 12;
    localparam int unsigned COUNT_SAT   = (1 << CNT_W) - 1;
    localparam int unsigned SETTLE_CYC  = 8;      // idle wait after draining, before config writes
    localparam int unsigned DRAIN_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 60;

    // DUT ports, inputs known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_push      = 1'b0;
    t_in_item              i_in        = '0;
    logic                  o_full;
    logic                  i_pop       = 1'b0;
    t_out_item             o_out;
    logic                  o_empty;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_AZ_OFFSET;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // stimulus and scoreboard storage
    t_in_item  pending_bytes[$];    // words waiting for the driver
    t_out_item expected_scans[$];   // predicted result words, oldest first
    int        err_cnt  = 0;
    bit        idle_on  = 1'b1;     // random gaps enabled on both sides
    int        hold_ask = 0;        // one long receiver hold-off, picked up by the receiver

    // predictor copy of the config registers (reset values)
    int unsigned az_offset_reg   = AZ_OFFSET_RST;
    int unsigned start_angle_reg = START_ANGLE_RST;
    int unsigned len_a_reg       = LEN_A_RST;
    int unsigned len_b_reg       = LEN_B_RST;

    // predictor copy of the block state
    int unsigned seen_bytes = 0;
    int unsigned az_lo_cap  = 0;
    int unsigned az_hi_cap  = 0;
    int unsigned last_phase = 0;
    int unsigned scan_count = 0;

    lidar_scan_boundary_detector #(
        .MAX_PACKET_BYTES(MAX_BYTES),
        .COUNT_WIDTH     (CNT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_in       (i_in),
        .o_full     (o_full),
        .i_pop      (i_pop),
        .o_out      (o_out),
        .o_empty    (o_empty),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: well past the slowest legal run (every word behind worst-case gaps/stalls).
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: advance the packet state by one accepted byte word and,
    // on the final byte, queue the result word it must produce.
    // ------------------------------------------------------------------
    function automatic void track_byte(t_in_item w);
        int unsigned idx;
        int unsigned len;
        int unsigned az;
        int unsigned sp;
        int unsigned ph;
        bit          ok;
        t_out_item   r;
        idx = seen_bytes;
        // bytes past the max packet size are never captured
        if (idx < MAX_BYTES) begin
            if (idx == az_offset_reg)
                az_lo_cap = w.data_byte;
            if (idx == az_offset_reg + 1)
                az_hi_cap = w.data_byte;
        end
        // counter parks one past the max so oversize is detectable
        if (seen_bytes <= MAX_BYTES)
            seen_bytes = seen_bytes + 1;
        if (!w.last_byte)
            return;

        len = seen_bytes;
        // only the lidar flag on the final byte matters
        ok = w.is_lidar && (len <= MAX_BYTES) && (len == len_a_reg || len == len_b_reg);
        r = '0;
        r.packet_accepted = ok;
        r.packet_length   = LEN_W'((len > MAX_BYTES) ? MAX_BYTES : len);
        if (ok) begin
            az = (az_hi_cap << 8) | az_lo_cap;
            sp = start_angle_reg % FULL_TURN;           // out-of-range start angle wraps
            ph = (az + FULL_TURN - sp) % FULL_TURN;     // out-of-range azimuth wraps too
            if (scan_count < COUNT_SAT)
                scan_count = scan_count + 1;
            r.packets_in_scan = OUT_COUNT_W'(scan_count);
            r.phase           = ANGLE_W'(ph);
            // phase going backwards closes the scan, after counting this packet
            if (ph < last_phase) begin
                r.scan_end = 1'b1;
                last_phase = 0;
                scan_count = 0;
            end else begin
                last_phase = ph;
            end
        end
        seen_bytes = 0;
        az_lo_cap  = 0;
        az_hi_cap  = 0;
        expected_scans.insert(expected_scans.size(), r);
    endfunction

    task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            if (err_cnt < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents pending words on the push side, with random idle
    // bursts. A word is held until the edge that takes it.
    // ------------------------------------------------------------------
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push   <= 1'b0;
            send_gap <= 0;
        end else if (!i_push || !o_full) begin
            // nothing held, or the held word goes in at this edge
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_push   <= 1'b0;
            end else if (pending_bytes.size() > 0 && idle_on && $urandom_range(0, 15) == 0) begin
                send_gap <= $urandom_range(1, 17) - 1;
                i_push   <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                i_in   <= pending_bytes.pop_front();
                i_push <= 1'b1;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // every word the block takes feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full)
            track_byte(i_in);
    end

    // ------------------------------------------------------------------
    // Receiver: pops with random stall bursts, plus one long hold-off
    // counted here so the result queue backs up and full asserts.
    // ------------------------------------------------------------------
    int recv_gap   = 0;
    int hold_left  = 0;
    bit hold_taken = 1'b0;

    always @(posedge i_clk) begin : receiver
        t_out_item want;
        if (!i_rst_n) begin
            i_pop    <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_scans.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t ns: result word with nothing expected, actual %p",
                                 $time, o_out);
                    err_cnt++;
                end else begin
                    want = expected_scans.pop_front();
                    cmp_field("packet_accepted", want.packet_accepted, o_out.packet_accepted);
                    cmp_field("phase",           want.phase,           o_out.phase);
                    cmp_field("scan_end",        want.scan_end,        o_out.scan_end);
                    cmp_field("packets_in_scan", want.packets_in_scan, o_out.packets_in_scan);
                    cmp_field("packet_length",   want.packet_length,   o_out.packet_length);
                end
            end
            if (hold_ask > 0 && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= hold_ask;
                i_pop      <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_pop     <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_pop    <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                recv_gap <= $urandom_range(1, 17) - 1;
                i_pop    <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Wait until every word is sent and every result is back, then let the
    // pipeline settle before touching config.
    task automatic drain();
        int n;
        n = 0;
        while ((pending_bytes.size() > 0 || i_push || expected_scans.size() > 0)
               && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // One register write; we drops again before the next write, so it never stays high across writes.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        unique case (idx)
            CFG_AZ_OFFSET:   az_offset_reg   = val[AZ_OFFSET_W-1:0];
            CFG_START_ANGLE: start_angle_reg = val;
            CFG_LEN_A:       len_a_reg       = val[LEN_W-1:0];
            CFG_LEN_B:       len_b_reg       = val[LEN_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_detector(int unsigned off, int unsigned sp,
                                    int unsigned la, int unsigned lb);
        drain();
        write_reg(CFG_AZ_OFFSET,   CFG_DATA_W'(off));
        write_reg(CFG_START_ANGLE, CFG_DATA_W'(sp));
        write_reg(CFG_LEN_A,       CFG_DATA_W'(la));
        write_reg(CFG_LEN_B,       CFG_DATA_W'(lb));
    endtask

    // Queue one packet; the azimuth lands at the current offset, other bytes
    // and non-final lidar flags are random.
    task automatic queue_packet(int unsigned len, bit lidar, logic [15:0] az);
        t_in_item w;
        for (int unsigned i = 0; i < len; i++) begin
            w.data_byte = 8'($urandom);
            if (i == az_offset_reg)
                w.data_byte = az[7:0];
            else if (i == az_offset_reg + 1)
                w.data_byte = az[15:8];
            w.is_lidar  = (i == len - 1) ? lidar : 1'($urandom_range(0, 1));
            w.last_byte = (i == len - 1);
            pending_bytes.insert(pending_bytes.size(), w);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned az_run;
        int unsigned la;
        int unsigned lb;
        int unsigned off;
        int unsigned sp;
        int unsigned len;
        int unsigned queued;
        int unsigned pick;
        logic [15:0] az;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: short packets miss both default lengths
        queue_packet(1, 1'b1, 16'd0);
        queue_packet(3, 1'b1, 16'd500);

        // directed: equal lengths, start angle at its top legal value
        program_detector(0, 35999, 4, 4);
        queue_packet(4, 1'b1, 16'd100);
        queue_packet(4, 1'b1, 16'hffff);        // azimuth out of range wraps
        queue_packet(4, 1'b0, 16'd200);         // final flag clear: rejected
        queue_packet(4, 1'b1, 16'd50);          // phase drops: scan ends
        queue_packet(5, 1'b1, 16'd70);          // wrong length

        // directed: azimuth only partly seen, start angle exactly one turn
        program_detector(2, FULL_TURN, 1, 3);
        queue_packet(3, 1'b1, 16'h1234);        // high byte never reached
        queue_packet(1, 1'b1, 16'h5555);        // no azimuth byte reached
        queue_packet(2, 1'b1, 16'h0101);        // length 2 matches neither

        // back pressure: one-byte packets, azimuth never seen so the phase is
        // constant; receiver holds off early so the block fills and stalls
        program_detector(5, 16'hffff, 1, MAX_BYTES);
        hold_ask = 800;
        for (int i = 0; i < 60; i++)
            queue_packet(1, 1'b1, 16'd0);

        // random phases: mostly well-formed packets with a running azimuth,
        // some wrong lengths, wrong type and wild azimuths
        az_run = 0;
        for (int ph = 0; ph < 7; ph++) begin
            pick = $urandom_range(0, 9);
            off  = (pick == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 24);
            pick = $urandom_range(0, 3);
            sp   = (pick == 0) ? 0 : (pick == 1) ? 35999 : $urandom_range(0, 65535);
            la   = $urandom_range(1, 16);
            lb   = ($urandom_range(0, 3) == 0) ? la : $urandom_range(1, 24);
            if (ph == 3)
                lb = 0;                         // never matches
            program_detector(off, sp, la, lb);
            if (ph == 6)
                idle_on = 1'b0;                 // last stretch runs flat out
            queued = 0;
            while (queued < 90) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    az_run = (az_run + $urandom_range(0, 3000)) % FULL_TURN;
                    az     = 16'(az_run);
                end else begin
                    az     = 16'($urandom_range(0, 65535));
                    az_run = az % FULL_TURN;
                end
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    len = ($urandom_range(0, 1) == 0) ? len_a_reg : len_b_reg;
                else
                    len = $urandom_range(1, 24);
                if (len == 0)
                    len = 1;
                queue_packet(len, $urandom_range(0, 9) != 0, az);
                queued += len;
            end
        end

        drain();
        if (expected_scans.size() != 0) begin
            $display("%0t ns: %0d result words never arrived, expected next %p",
                     $time, expected_scans.size(), expected_scans[0]);
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
